// ----- design/lrs_pkg.sv -----
package lrs_pkg;

  localparam logic [7:0]  LfCode   = 8'h0A;
  localparam logic [7:0]  CrCode   = 8'h0D;
  localparam logic [30:0] CountMax = 31'h7FFF_FFFF;

  localparam logic [15:0] LineLenReset = 16'hFFFF;
  localparam logic [30:0] BudgetReset  = 31'h7FFF_FFFF;

  // config register indexes
  typedef enum logic [0:0] {
    CfgMaxLineLength  = 1'b0,
    CfgMaxBytesBudget = 1'b1
  } cfg_idx_e;

  // result queue geometry
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;
  localparam int unsigned OutCntW  = 3;
  localparam logic [OutCntW-1:0] OutStallLevel = 3'(OutDepth - 1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        record_end;
    logic [30:0] consumed_bytes;
    logic        end_of_file;
    logic        last;
  } result_t;

  // up to two results per accepted byte; a single result always uses slot 0
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

// ----- design/line_record_splitter_unit.sv -----
// Line record splitter: turns a text byte stream into line records.
// Input channel: one request per byte (in_byte_i), or an end-of-file marker
//   (input_end_i = 1, byte ignored); taken when in_valid_i && !in_stall_o.
// Output channel: one request per result; taken when out_valid_o &&
//   !out_stall_i. A byte yields zero, one or two results; last_o flags the
//   final one for that byte. Terminators (LF, CR, CR LF) never show up as data.
// Config: cfg_we_i writes register cfg_idx_i (0 max line length, 1 byte budget)
//   from cfg_wdata_i; write only while the block is idle.
// Each result is registered in the result queue when its byte is taken.
// Throughput: one byte per cycle while no byte makes two results and
//   out_stall_i is low; a byte that makes two results (record closed by a
//   lone CR plus a new record byte) sends them in turn on the single port.
// A four-entry result queue sits between the two sides; input stalls while
//   fewer than two entries are free, so out_stall_i backs up into in_stall_o
//   and nothing is lost.
// Reset: asynchronous, active low; clears record state and queue, restores
//   max line length 65535 and budget 2^31-1.
module line_record_splitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        input_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        record_end_o,
  output logic [30:0] consumed_bytes_o,
  output logic        end_of_file_o,
  output logic        last_o
);
  import lrs_pkg::*;

  push_t   push;
  result_t res;
  logic    full;
  logic    acc;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  // per-byte line/record logic and its state
  lrs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .in_byte_i   (in_byte_i),
    .input_end_i (input_end_i),
    .push_o      (push)
  );

  // result queue, also the output register
  lrs_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_byte_o       = res.out_byte;
  assign byte_valid_o     = res.byte_valid;
  assign record_end_o     = res.record_end;
  assign consumed_bytes_o = res.consumed_bytes;
  assign end_of_file_o    = res.end_of_file;
  assign last_o           = res.last;

endmodule

// ----- design/lrs_core.sv -----
module lrs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [30:0]       cfg_wdata_i,
  input  logic              acc_i,
  input  logic [7:0]        in_byte_i,
  input  logic              input_end_i,
  output lrs_pkg::push_t    push_o
);
  import lrs_pkg::*;

  logic [15:0] max_len_q;
  logic [30:0] budget_q;
  logic        seen_q, seen_d;
  logic [15:0] kept_q, kept_d;
  logic [30:0] cnt_q, cnt_d;

  logic [30:0] cnt_base, cnt_inc;
  logic [15:0] kept_base;
  logic        is_lf, is_cr, kept, close_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LineLenReset;
      budget_q  <= BudgetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMaxLineLength:  max_len_q <= cfg_wdata_i[15:0];
        CfgMaxBytesBudget: budget_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      kept_q <= '0;
      cnt_q  <= '0;
    end else begin
      seen_q <= seen_d;
      kept_q <= kept_d;
      cnt_q  <= cnt_d;
    end
  end

  always_comb begin
    is_lf     = (in_byte_i == LfCode);
    is_cr     = (in_byte_i == CrCode);
    // a lone pending CR closes its record first, so the byte starts fresh
    cnt_base  = seen_q ? '0 : cnt_q;
    kept_base = seen_q ? '0 : kept_q;
    cnt_inc   = (cnt_base < CountMax) ? cnt_base + 31'd1 : cnt_base;
    kept      = !is_lf && !is_cr && (kept_base < max_len_q);
    close_rec = is_lf || (cnt_inc >= budget_q);

    push_o = '0;
    seen_d = seen_q;
    kept_d = kept_q;
    cnt_d  = cnt_q;

    if (acc_i) begin
      if (input_end_i) begin
        push_o.push0               = 1'b1;
        push_o.res0.record_end     = 1'b1;
        push_o.res0.consumed_bytes = cnt_q;
        push_o.res0.end_of_file    = 1'b1;
        push_o.res0.last           = 1'b1;
        seen_d = 1'b0;
        kept_d = '0;
        cnt_d  = '0;
      end else if (seen_q && is_lf) begin
        // CR LF: the LF is counted in the record it closes
        push_o.push0               = 1'b1;
        push_o.res0.record_end     = 1'b1;
        push_o.res0.consumed_bytes = cnt_q + 31'd1;
        push_o.res0.last           = 1'b1;
        seen_d = 1'b0;
        kept_d = '0;
        cnt_d  = '0;
      end else begin
        if (seen_q) begin
          push_o.push0               = 1'b1;
          push_o.res0.record_end     = 1'b1;
          push_o.res0.consumed_bytes = cnt_q;
          push_o.res0.last           = !(kept || close_rec);
          if (kept || close_rec) begin
            push_o.push1                    = 1'b1;
            push_o.res1.out_byte            = kept ? in_byte_i : '0;
            push_o.res1.byte_valid          = kept;
            push_o.res1.record_end          = close_rec;
            push_o.res1.consumed_bytes      = close_rec ? cnt_inc : '0;
            push_o.res1.last                = 1'b1;
          end
        end else if (kept || close_rec) begin
          push_o.push0               = 1'b1;
          push_o.res0.out_byte       = kept ? in_byte_i : '0;
          push_o.res0.byte_valid     = kept;
          push_o.res0.record_end     = close_rec;
          push_o.res0.consumed_bytes = close_rec ? cnt_inc : '0;
          push_o.res0.last           = 1'b1;
        end
        if (close_rec) begin
          seen_d = 1'b0;
          kept_d = '0;
          cnt_d  = '0;
        end else begin
          seen_d = is_cr;
          kept_d = kept_base + {15'd0, kept};
          cnt_d  = cnt_inc;
        end
      end
    end
  end

endmodule

// ----- design/lrs_out_buf.sv -----
module lrs_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrs_pkg::push_t   push_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lrs_pkg::result_t res_o
);
  import lrs_pkg::*;

  result_t              mem_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [OutCntW-1:0]   cnt_q;
  logic                 pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  // keep room for two results at all times before taking a byte
  assign full_o      = (cnt_q >= OutStallLevel);
  assign res_o       = mem_q[rd_ptr_q];
  assign wr_ptr_nx   = wr_ptr_q + OutPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.push0) mem_q[wr_ptr_q]  <= push_i.res0;
    if (push_i.push1) mem_q[wr_ptr_nx] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutPtrW'(push_i.push0) + OutPtrW'(push_i.push1);
      rd_ptr_q <= rd_ptr_q + OutPtrW'(pop);
      cnt_q    <= cnt_q + OutCntW'(push_i.push0) + OutCntW'(push_i.push1)
                  - OutCntW'(pop);
    end
  end

endmodule

// ----- design/lrs_checker.sv -----
module lrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        input_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        byte_valid_o,
  input logic        record_end_o,
  input logic [30:0] consumed_bytes_o,
  input logic        end_of_file_o,
  input logic        last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // end of file always yields a result
  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && input_end_i |=> out_valid_o)
    else $error("no result after end of file");

  // a result that closes nothing must carry a byte
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_end_o |-> byte_valid_o)
    else $error("empty result");

  // record fields are zero outside a record end
  a_rec_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_end_o |-> consumed_bytes_o == 31'd0 && !end_of_file_o)
    else $error("record fields set without record end");

  // end of file is always the final result of its request
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_file_o |-> last_o && record_end_o)
    else $error("end of file not last");

endmodule

bind line_record_splitter_unit lrs_checker u_lrs_checker (.*);
